// ----- rtl/linear_partition_min_max_sum_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the linear partition block.
// Each macro takes a label, the clock, the reset and the property operands.
// Defining ASSERT_OFF turns every check into an empty statement.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PARTITION_MIN_MAX_SUM_DEFINES_SVH
`define LINEAR_PARTITION_MIN_MAX_SUM_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define LPMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpms assertion failed");

`else

`define LPMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/lpms_pkg.sv -----
// ---------------------------------------------------------------------------
// lpms_pkg
// Shared types and constants of the linear partition block.
// ---------------------------------------------------------------------------
package lpms_pkg;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_ITEMS   = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  // Group count register.
  localparam int               NUM_PARTS_W   = 11;
  localparam logic [10:0]      NUM_PARTS_RST = 11'd2;

  // Result word layout.
  localparam int RESULT_W   = 26;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - RESULT_W;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_MID,
    ST_LAUNCH,
    ST_PROBE,
    ST_DONE
  } state_t;

  // Controller to probe walker.
  typedef struct packed {
    logic start;
  } probe_ctl_t;

  // Probe walker to controller.
  typedef struct packed {
    logic done;
    logic fits;
  } probe_sts_t;

endpackage

// ----- rtl/lpms_mem.sv -----
// ---------------------------------------------------------------------------
// lpms_mem
// Weight store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lpms_mem #(
  parameter int DEPTH  = lpms_pkg::DEF_MAX_ITEMS,
  parameter int WIDTH  = lpms_pkg::DEF_WEIGHT_BITS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lpms_probe.sv -----
// ---------------------------------------------------------------------------
// lpms_probe
// Greedy walker: streams the stored weights once and counts the groups
// that a fill with the given cap opens.
// ---------------------------------------------------------------------------
`include "linear_partition_min_max_sum_defines.svh"

module lpms_probe #(
  parameter int MAX_ITEMS   = lpms_pkg::DEF_MAX_ITEMS,
  parameter int WEIGHT_BITS = lpms_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  lpms_pkg::probe_ctl_t                             ctl,
  output lpms_pkg::probe_sts_t                             sts,
  input  logic [$clog2(MAX_ITEMS+1)+WEIGHT_BITS-1:0]       cap,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]                   count,
  input  logic [lpms_pkg::NUM_PARTS_W-1:0]                 num_parts,
  output logic                                             rd_en,
  output logic [$clog2(MAX_ITEMS)-1:0]                     rd_addr,
  input  logic [WEIGHT_BITS-1:0]                           rd_data
);

  import lpms_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int SUM_W  = CNT_W + WEIGHT_BITS;
  localparam int CMP_W  = (CNT_W > NUM_PARTS_W) ? CNT_W : NUM_PARTS_W;

  logic             run;
  logic [CNT_W-1:0] idx;
  logic             data_vld;
  logic [SUM_W:0]   run_sum;
  logic [CNT_W-1:0] groups;

  logic             issue;
  logic [SUM_W:0]   w_ext;
  logic [SUM_W:0]   add;
  logic             overflow;

  assign issue    = run && (idx != count);
  assign rd_en    = issue;
  assign rd_addr  = idx[ADDR_W-1:0];
  assign w_ext    = (SUM_W + 1)'(rd_data);
  assign add      = run_sum + w_ext;
  assign overflow = add > {1'b0, cap};

  // The walk is over once every read has been issued and its data used.
  assign sts.done = run && !issue && !data_vld;
  assign sts.fits = CMP_W'(groups) <= CMP_W'(num_parts);

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      data_vld <= 1'b0;
    end else begin
      data_vld <= issue;
      if (ctl.start) begin
        run <= 1'b1;
      end else if (sts.done) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx     <= '0;
      run_sum <= '0;
      groups  <= CNT_W'(1);
    end else begin
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (data_vld) begin
        if (overflow) begin
          groups  <= groups + CNT_W'(1);
          run_sum <= w_ext;
        end else begin
          run_sum <= add;
        end
      end
    end
  end

  // The read pointer never runs past the item count.
  `LPMS_ASSERT_IMP(a_idx_in_range, clk, rst, run, idx <= count)
  // With a cap of at least the largest weight every group holds an item.
  `LPMS_ASSERT_IMP(a_groups_bound, clk, rst, sts.done, groups <= count)
  // A new walk is only launched once the previous one has finished.
  `LPMS_ASSERT_IMP(a_no_restart, clk, rst, ctl.start, !run)

endmodule

// ----- rtl/lpms_ctrl.sv -----
// ---------------------------------------------------------------------------
// lpms_ctrl
// Load bookkeeping and binary search sequencer.
// ---------------------------------------------------------------------------
`include "linear_partition_min_max_sum_defines.svh"

module lpms_ctrl #(
  parameter int MAX_ITEMS   = lpms_pkg::DEF_MAX_ITEMS,
  parameter int WEIGHT_BITS = lpms_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [WEIGHT_BITS-1:0]                     item_weight,
  input  logic                                       last_item,
  input  logic [lpms_pkg::NUM_PARTS_W-1:0]           num_parts,
  output logic                                       wr_en,
  output logic [$clog2(MAX_ITEMS)-1:0]               wr_addr,
  output logic [$clog2(MAX_ITEMS+1)-1:0]             count,
  output lpms_pkg::probe_ctl_t                       ctl,
  input  lpms_pkg::probe_sts_t                       sts,
  output logic [$clog2(MAX_ITEMS+1)+WEIGHT_BITS-1:0] cap,
  output logic                                       res_valid,
  input  logic                                       res_taken,
  output logic [$clog2(MAX_ITEMS+1)+WEIGHT_BITS-1:0] res_best,
  output logic                                       res_nosol
);

  import lpms_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int SUM_W  = CNT_W + WEIGHT_BITS;
  localparam int CMP_W  = (CNT_W > NUM_PARTS_W) ? CNT_W : NUM_PARTS_W;

  state_t state, state_next;

  logic [SUM_W-1:0]       total;
  logic [WEIGHT_BITS-1:0] largest;
  logic [SUM_W-1:0]       low;
  logic [SUM_W-1:0]       high;
  logic [SUM_W-1:0]       mid;
  logic [SUM_W-1:0]       best;
  logic                   nosol;

  logic                   short_set;
  logic [SUM_W:0]         mid_sum;

  assign short_set = (num_parts == '0) || (CMP_W'(count) < CMP_W'(num_parts));
  assign mid_sum   = {1'b0, low} + {1'b0, high};
  assign wr_en     = in_valid && in_ready && (count != CNT_W'(MAX_ITEMS));
  assign wr_addr   = count[ADDR_W-1:0];
  assign cap       = mid;
  assign res_best  = best;
  assign res_nosol = nosol;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl.start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && last_item) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = short_set ? ST_DONE : ST_MID;
      end
      ST_MID: begin
        state_next = (low <= high) ? ST_LAUNCH : ST_DONE;
      end
      ST_LAUNCH: begin
        ctl.start  = 1'b1;
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.done) begin
          state_next = (sts.fits && (mid == '0)) ? ST_DONE : ST_MID;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      total   <= '0;
      largest <= '0;
      low     <= '0;
      high    <= '0;
      best    <= '0;
      nosol   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (wr_en) begin
            count <= count + CNT_W'(1);
            total <= total + SUM_W'(item_weight);
            if (item_weight > largest) begin
              largest <= item_weight;
            end
          end
        end
        ST_START: begin
          if (short_set) begin
            best  <= '0;
            nosol <= 1'b1;
          end else begin
            low   <= SUM_W'(largest);
            high  <= total;
            best  <= total;
            nosol <= 1'b0;
          end
        end
        ST_PROBE: begin
          if (sts.done) begin
            if (sts.fits) begin
              best <= mid;
              if (mid != '0) begin
                high <= mid - SUM_W'(1);
              end
            end else begin
              low <= mid + SUM_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (res_taken) begin
            count   <= '0;
            total   <= '0;
            largest <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The probe cap is kept apart from the reset so its path stays plain.
  always_ff @(posedge clk) begin
    if (state == ST_MID) begin
      mid <= mid_sum[SUM_W:1];
    end
  end

  // Every probe cap lies inside the current search window.
  `LPMS_ASSERT_IMP(a_mid_in_window, clk, rst, state == ST_PROBE, (mid >= low) && (mid <= high))
  // A solved set reports a value between the largest weight and the total.
  `LPMS_ASSERT_IMP(a_best_bounds, clk, rst, res_valid && !nosol,
                   (best >= SUM_W'(largest)) && (best <= total))
  // Handing off a result clears the load state for the next set.
  `LPMS_ASSERT_NEXT(a_clear_after_result, clk, rst, res_valid && res_taken,
                    (count == '0) && (state == ST_LOAD))

endmodule

// ----- rtl/linear_partition_min_max_sum.sv -----
// ---------------------------------------------------------------------------
// linear_partition_min_max_sum
// Splits a stored run of weights into num_parts non-empty contiguous groups
// with the smallest possible largest group sum, by binary search on the cap.
// ---------------------------------------------------------------------------
//
//   Channel | Dir | Handshake          | Payload
//   --------+-----+--------------------+------------------------------------
//   s_      | in  | s_tvalid/s_tready  | s_tdata = item_weight, s_tuser = last_item
//   m_      | out | m_tvalid/m_tready  | m_tdata = best_max_sum, m_tuser = no_solution
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_data = num_parts
//
// Loading accepts one word per cycle; a word after the store holds MAX_ITEMS
// items is dropped, but a marked one still starts the search.
// The search then runs roughly log2(total - largest) + 1 probes. Each probe
// walks the weight store through its single read port in these steps: mid
// compute, launch, one read per stored item, read latency, finish. A set too
// short for num_parts passes from its end through the start state to done.
// Input words are taken only while loading; the finished result sits in the
// output register, so the next set can load while it waits to be taken.
// The store holds no reset state; rst clears only control and bookkeeping,
// and num_parts returns to 2. Configuration is always accepted.
// Loading and probing never overlap, so the store needs no forwarding.
// ---------------------------------------------------------------------------
module linear_partition_min_max_sum #(
  parameter int  MAX_ITEMS   = lpms_pkg::DEF_MAX_ITEMS,
  parameter int  WEIGHT_BITS = lpms_pkg::DEF_WEIGHT_BITS,
  localparam int IN_DATA_W   = ((WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input words.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [IN_DATA_W-1:0]                 s_tdata,   // item_weight
  input  logic                                 s_tuser,   // last_item
  // Result words.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lpms_pkg::OUT_DATA_W-1:0]      m_tdata,   // best_max_sum, zero pad
  output logic                                 m_tuser,   // no_solution
  // Group count register.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpms_pkg::NUM_PARTS_W-1:0]     cfg_data   // num_parts
);

  import lpms_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int SUM_W  = CNT_W + WEIGHT_BITS;

  logic [NUM_PARTS_W-1:0] num_parts;

  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       cap;
  probe_ctl_t             ctl;
  probe_sts_t             sts;

  logic                   res_valid;
  logic                   res_taken;
  logic [SUM_W-1:0]       res_best;
  logic                   res_nosol;

  logic [RESULT_W-1:0]    best_out;
  logic                   nosol_out;

  // Only the low WEIGHT_BITS bits of a weight word take part.
  logic [WEIGHT_BITS-1:0] item_weight;
  assign item_weight = s_tdata[WEIGHT_BITS-1:0];

  // Configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_parts <= NUM_PARTS_RST;
    end else if (cfg_valid) begin
      num_parts <= cfg_data;
    end
  end

  lpms_ctrl #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .item_weight (item_weight),
    .last_item   (s_tuser),
    .num_parts   (num_parts),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .count       (count),
    .ctl         (ctl),
    .sts         (sts),
    .cap         (cap),
    .res_valid   (res_valid),
    .res_taken   (res_taken),
    .res_best    (res_best),
    .res_nosol   (res_nosol)
  );

  lpms_mem #(
    .DEPTH  (MAX_ITEMS),
    .WIDTH  (WEIGHT_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item_weight),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpms_probe #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_probe (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cap       (cap),
    .count     (count),
    .num_parts (num_parts),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Output register: a result moves in whenever the slot is empty or is
  // being emptied in the same cycle.
  assign res_taken = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The reported sum keeps its low RESULT_W bits.
  always_ff @(posedge clk) begin
    if (res_taken) begin
      best_out  <= RESULT_W'(res_best);
      nosol_out <= res_nosol;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, best_out};
  assign m_tuser = nosol_out;

endmodule
